// ----- hdl/great_circle_distance_assert.svh -----
// assertion macros shared by the great circle distance pipeline
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gcd_pkg.sv -----
// constants and elaboration-time table functions for the distance pipeline
`timescale 1ns / 1ps
package gcd_pkg;
	localparam int IN_W = 88;
	localparam int OUT_W = 24;
	localparam int DIST_W = 21;
	localparam int ASEC_W = 22;
	localparam int MAG_W = 19;
	localparam int ROOT_W = 32;
	localparam int RAD_W = 64;
	localparam int VEC_W = 36;
	localparam int FULL_TURN = 1296000;
	localparam int HALF_TURN = 648000;
	localparam int QUARTER_TURN = 324000;
	localparam longint unsigned PI61 = 64'h6487ED5110B4611A;
	localparam longint unsigned ARCSEC_K61 = (PI61 + 64'd324000) / 64'd648000;
	localparam longint unsigned GAIN62 = 64'd2800459870029452954;
	localparam longint unsigned DIST_K20 = 64'd668822457549;

	// shift-subtract division, only used to build constant tables
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) with 62 fraction bits from the arctangent series
	function automatic longint unsigned atan_q62(input int i);
		longint unsigned acc;
		longint unsigned term;
		int e;
		acc = 64'd0;
		if (i == 0) begin
			acc = (PI61 + 64'd1) >> 1;
		end else begin
			for (int k = 0; k < 32; k++) begin
				e = i * (2 * k + 1);
				if (e <= 62) begin
					term = udiv64(64'd1 << (62 - e), longint'(2 * k + 1));
					if ((k & 1) != 0) begin
						acc = acc - term;
					end else begin
						acc = acc + term;
					end
				end
			end
		end
		return acc;
	endfunction

	function automatic longint unsigned atan_entry(input int i, input int f);
		return (atan_q62(i) + (64'd1 << (61 - f))) >> (62 - f);
	endfunction
endpackage

// ----- hdl/gcd_sincos.sv -----
// angle reduction and pipelined rotation cordic giving cosine and sine
`timescale 1ns / 1ps
module gcd_sincos #(
	parameter int F = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic signed [gcd_pkg::ASEC_W-1:0] asec,
	output logic out_vld,
	output logic signed [F+1:0] cos_v,
	output logic signed [F+1:0] sin_v
);
	localparam int W = F + 3;
	localparam int AW = gcd_pkg::ASEC_W;
	localparam int MW = gcd_pkg::MAG_W;
	localparam logic signed [AW-1:0] FULL_S = AW'(gcd_pkg::FULL_TURN);
	localparam logic signed [AW-1:0] HALF_S = AW'(gcd_pkg::HALF_TURN);
	localparam logic signed [AW-1:0] QTR_S = AW'(gcd_pkg::QUARTER_TURN);
	localparam logic [31:0] K_LO = 32'(gcd_pkg::ARCSEC_K61);
	localparam logic [28:0] K_HI = 29'(gcd_pkg::ARCSEC_K61 >> 32);
	localparam logic [79:0] RND = 80'd1 << (60 - F);
	localparam logic signed [W-1:0] X0 =
		W'((gcd_pkg::GAIN62 + (64'd1 << (61 - F))) >> (62 - F));

	logic signed [AW-1:0] r0, r1;
	logic fold;
	logic [79:0] prod;
	logic signed [W-1:0] ang;

	logic vld_s1, rneg_s1, fold_s1;
	logic [MW-1:0] mag_s1;
	logic vld_s2, rneg_s2, fold_s2;
	logic [MW+31:0] plo_s2;
	logic [MW+28:0] phi_s2;

	logic cvld_s [0:F];
	logic cfold_s [0:F];
	logic signed [W-1:0] cx_s [0:F];
	logic signed [W-1:0] cy_s [0:F];
	logic signed [W-1:0] cz_s [0:F];

	// reduce to (-180, 180] then fold into [-90, 90]
	always_comb begin
		r0 = asec;
		if (r0 > HALF_S) begin
			r0 = r0 - FULL_S;
		end
		if (r0 <= -HALF_S) begin
			r0 = r0 + FULL_S;
		end
		fold = 1'b0;
		r1 = r0;
		if (r0 > QTR_S) begin
			r1 = r0 - HALF_S;
			fold = 1'b1;
		end else if (r0 < -QTR_S) begin
			r1 = r0 + HALF_S;
			fold = 1'b1;
		end
	end

	always_comb begin
		prod = {phi_s2, 32'b0} + 80'(plo_s2) + RND;
		ang = signed'(W'((F+1)'(prod >> (61 - F))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			cvld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			cvld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= MW'(r1[AW-1] ? -r1 : r1);
			rneg_s1 <= r1[AW-1];
			fold_s1 <= fold;
			plo_s2 <= (MW+32)'(mag_s1) * (MW+32)'(K_LO);
			phi_s2 <= (MW+29)'(mag_s1) * (MW+29)'(K_HI);
			rneg_s2 <= rneg_s1;
			fold_s2 <= fold_s1;
			cx_s[0] <= X0;
			cy_s[0] <= '0;
			cz_s[0] <= rneg_s2 ? -ang : ang;
			cfold_s[0] <= fold_s2;
		end
	end

	for (genvar i = 0; i < F; i++) begin : g_rot
		localparam logic signed [W-1:0] ATAN = W'(gcd_pkg::atan_entry(i, F));
		logic signed [W-1:0] dx, dy;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[i+1] <= 1'b0;
			end else if (en) begin
				cvld_s[i+1] <= cvld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cfold_s[i+1] <= cfold_s[i];
				if (!cz_s[i][W-1]) begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - ATAN;
				end else begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + ATAN;
				end
			end
		end
	end

	// a fold by half a turn flips both signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= cvld_s[F];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= (F+2)'(cfold_s[F] ? -cx_s[F] : cx_s[F]);
			sin_v <= (F+2)'(cfold_s[F] ? -cy_s[F] : cy_s[F]);
		end
	end
endmodule

// ----- hdl/gcd_product.sv -----
// cosine of the central angle from two sin/cos pairs and cos_d, clamped
`timescale 1ns / 1ps
module gcd_product #(
	parameter int F = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic signed [F+1:0] sin_a,
	input  logic signed [F+1:0] cos_a,
	input  logic signed [F+1:0] sin_b,
	input  logic signed [F+1:0] cos_b,
	input  logic signed [F+1:0] cos_d,
	output logic out_vld,
	output logic signed [F+1:0] c
);
	localparam int MW = F + 1;
	localparam int PW = 2 * MW;
	localparam int RW = F + 2;
	localparam int P3 = RW + MW;
	localparam int SW = F + 3;
	localparam logic [PW-1:0] RND2 = PW'(1) << (F - 1);
	localparam logic [P3-1:0] RND3 = P3'(1) << (F - 1);
	localparam logic signed [SW:0] ONE_E = (SW+1)'(64'd1 << F);

	function automatic logic [MW-1:0] mag(input logic signed [F+1:0] v);
		return MW'(v[F+1] ? -v : v);
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PW-1:0] mss_s1, mcc_s1;
	logic nss_s1, ncc_s1;
	logic signed [F+1:0] cd_s1, cd_s2;
	logic [RW-1:0] rss_s2, rcc_s2;
	logic nss_s2, ncc_s2;
	logic [P3-1:0] m3_s3;
	logic n3_s3;
	logic signed [SW-1:0] ssv_s3, ssv_s4, v3_s4;
	logic signed [SW-1:0] ssv_c, r3_c;
	logic signed [SW:0] sum_c, clamp_c;

	assign ssv_c = signed'(SW'(rss_s2));
	assign r3_c = signed'(SW'((m3_s3 + RND3) >> F));

	always_comb begin
		sum_c = (SW+1)'(ssv_s4) + (SW+1)'(v3_s4);
		clamp_c = sum_c;
		if (sum_c > ONE_E) begin
			clamp_c = ONE_E;
		end else if (sum_c < -ONE_E) begin
			clamp_c = -ONE_E;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_vld <= vld_s4;
		end
	end

	// products in sign and magnitude, rounded half away from zero
	always_ff @(posedge clk) begin
		if (en) begin
			mss_s1 <= PW'(mag(sin_a)) * PW'(mag(sin_b));
			nss_s1 <= sin_a[F+1] ^ sin_b[F+1];
			mcc_s1 <= PW'(mag(cos_a)) * PW'(mag(cos_b));
			ncc_s1 <= cos_a[F+1] ^ cos_b[F+1];
			cd_s1 <= cos_d;
			rss_s2 <= RW'((mss_s1 + RND2) >> F);
			rcc_s2 <= RW'((mcc_s1 + RND2) >> F);
			nss_s2 <= nss_s1;
			ncc_s2 <= ncc_s1;
			cd_s2 <= cd_s1;
			m3_s3 <= P3'(rcc_s2) * P3'(mag(cd_s2));
			n3_s3 <= ncc_s2 ^ cd_s2[F+1];
			ssv_s3 <= nss_s2 ? -ssv_c : ssv_c;
			v3_s4 <= n3_s3 ? -r3_c : r3_c;
			ssv_s4 <= ssv_s3;
			c <= (F+2)'(clamp_c);
		end
	end
endmodule

// ----- hdl/gcd_sqrt.sv -----
// pipelined floor square root, one root bit per stage
`timescale 1ns / 1ps
module gcd_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [gcd_pkg::RAD_W-1:0] op,
	output logic out_vld,
	output logic [gcd_pkg::ROOT_W-1:0] root
);
	localparam int NW = gcd_pkg::RAD_W;
	localparam int NB = gcd_pkg::ROOT_W;

	logic vld_s [0:NB-1];
	logic [NW-1:0] v_s [0:NB-1];
	logic [NW-1:0] r_s [0:NB-1];

	for (genvar k = 0; k < NB; k++) begin : g_bit
		localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
		logic [NW-1:0] vi, ri, sum;
		logic vldi, take;
		if (k == 0) begin : g_first
			assign vi = op;
			assign ri = '0;
			assign vldi = in_vld;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign ri = r_s[k-1];
			assign vldi = vld_s[k-1];
		end
		assign sum = ri + BIT;
		assign take = (vi >= sum);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vldi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k] <= take ? vi - sum : vi;
				r_s[k] <= take ? (ri >> 1) + BIT : ri >> 1;
			end
		end
	end

	assign out_vld = vld_s[NB-1];
	assign root = NB'(r_s[NB-1]);
endmodule

// ----- hdl/gcd_arc.sv -----
// vectoring cordic for the central angle and scaling to hundredths of a km
`timescale 1ns / 1ps
module gcd_arc #(
	parameter int F = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [gcd_pkg::ROOT_W-1:0] root_x,
	input  logic [gcd_pkg::ROOT_W-1:0] root_y,
	output logic out_vld,
	output logic [gcd_pkg::DIST_W-1:0] dist_centikm
);
	localparam int VW = gcd_pkg::VEC_W;
	localparam int ZW = F + 3;
	localparam int TW = F + 2;
	localparam int SUMW = TW + 41;
	localparam logic [31:0] K_LO = 32'(gcd_pkg::DIST_K20);
	localparam logic [7:0] K_HI = 8'(gcd_pkg::DIST_K20 >> 32);
	localparam logic [SUMW-1:0] RND = SUMW'(1) << (F + 19);

	logic avld_s [0:F-1];
	logic signed [VW-1:0] ax_s [0:F-1];
	logic signed [VW-1:0] ay_s [0:F-1];
	logic signed [ZW-1:0] az_s [0:F-1];

	for (genvar i = 0; i < F; i++) begin : g_vec
		localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_entry(i, F));
		logic signed [VW-1:0] xi, yi, dx, dy;
		logic signed [ZW-1:0] zi;
		logic vldi;
		if (i == 0) begin : g_first
			assign xi = signed'(VW'(root_x));
			assign yi = signed'(VW'(root_y));
			assign zi = '0;
			assign vldi = in_vld;
		end else begin : g_next
			assign xi = ax_s[i-1];
			assign yi = ay_s[i-1];
			assign zi = az_s[i-1];
			assign vldi = avld_s[i-1];
		end
		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				avld_s[i] <= 1'b0;
			end else if (en) begin
				avld_s[i] <= vldi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[VW-1]) begin
					ax_s[i] <= xi + dx;
					ay_s[i] <= yi - dy;
					az_s[i] <= zi + ATAN;
				end else begin
					ax_s[i] <= xi - dx;
					ay_s[i] <= yi + dy;
					az_s[i] <= zi - ATAN;
				end
			end
		end
	end

	logic [TW-1:0] theta;
	logic vld_s1;
	logic [TW+31:0] plo_s1;
	logic [TW+7:0] phi_s1;
	logic [SUMW-1:0] sum_c;

	// acos is twice the accumulated angle, negative clamps to zero
	assign theta = az_s[F-1][ZW-1] ? '0 : TW'({az_s[F-1], 1'b0});
	assign sum_c = (SUMW'(phi_s1) << 32) + SUMW'(plo_s1) + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= avld_s[F-1];
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= (TW+32)'(theta) * (TW+32)'(K_LO);
			phi_s1 <= (TW+8)'(theta) * (TW+8)'(K_HI);
			dist_centikm <= gcd_pkg::DIST_W'(sum_c >> (F + 20));
		end
	end
endmodule

// ----- hdl/great_circle_distance.sv -----
// Great circle distance between two points given in degrees, minutes and
// seconds, by the spherical law of cosines on a 6378.388 km sphere, result in
// hundredths of a km. Fully pipelined: one word in and one word out per cycle
// while the output is not stalled, with the two cordic chains of ANGLE_FRAC_BITS
// stages each and the 32-stage square roots in the path.
// A stalled output word freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps
`include "great_circle_distance_assert.svh"
module great_circle_distance #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// lat_a_deg, lat_a_min, lat_a_sec, lon_a_deg, lon_a_min, lon_a_sec,
	// lat_b_deg, lat_b_min, lat_b_sec, lon_b_deg, lon_b_min, lon_b_sec
	input  logic [gcd_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// distance_centikm
	output logic [gcd_pkg::OUT_W-1:0] m_tdata
);
	localparam int F = ANGLE_FRAC_BITS;
	localparam int AW = gcd_pkg::ASEC_W;
	localparam logic signed [AW-1:0] DEG_ASEC = AW'(3600);
	localparam logic signed [AW-1:0] MIN_ASEC = AW'(60);
	localparam logic signed [F+2:0] ONE_C = (F+3)'(64'd1 << F);

	function automatic logic signed [AW-1:0] to_asec(input logic signed [AW-1:0] deg,
			input logic [5:0] mn, input logic [5:0] sc);
		logic signed [AW-1:0] m, s;
		m = signed'(AW'(mn));
		s = signed'(AW'(sc));
		return deg * DEG_ASEC + m * MIN_ASEC + s;
	endfunction

	logic en;
	logic vld_s1;
	logic signed [AW-1:0] lat_a_c, lon_a_c, lat_b_c, lon_b_c;
	logic signed [AW-1:0] lat_a_s1, lat_b_s1, dlon_s1;
	logic sc_vld;
	logic signed [F+1:0] ca, sa, cb, sb, cd;
	logic prod_vld;
	logic signed [F+1:0] c_val;
	logic [F+2:0] one_m_c, one_p_c;
	logic [gcd_pkg::RAD_W-1:0] op_y, op_x;
	logic rt_vld;
	logic [gcd_pkg::ROOT_W-1:0] root_x, root_y;
	logic [gcd_pkg::DIST_W-1:0] dist_centikm;

	// pipeline advances unless the output word is held
	assign en = m_tready || !m_tvalid;
	assign s_tready = en;

	assign lat_a_c = to_asec(AW'(signed'(s_tdata[7:0])), s_tdata[13:8], s_tdata[19:14]);
	assign lon_a_c = to_asec(AW'(signed'(s_tdata[28:20])), s_tdata[34:29], s_tdata[40:35]);
	assign lat_b_c = to_asec(AW'(signed'(s_tdata[48:41])), s_tdata[54:49], s_tdata[60:55]);
	assign lon_b_c = to_asec(AW'(signed'(s_tdata[69:61])), s_tdata[75:70], s_tdata[81:76]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_a_s1 <= lat_a_c;
			lat_b_s1 <= lat_b_c;
			dlon_s1 <= lon_b_c - lon_a_c;
		end
	end

	gcd_sincos #(.F(F)) u_sc_lat_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .asec(lat_a_s1),
		.out_vld(sc_vld), .cos_v(ca), .sin_v(sa)
	);

	gcd_sincos #(.F(F)) u_sc_lat_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .asec(lat_b_s1),
		.out_vld(), .cos_v(cb), .sin_v(sb)
	);

	gcd_sincos #(.F(F)) u_sc_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .asec(dlon_s1),
		.out_vld(), .cos_v(cd), .sin_v()
	);

	gcd_product #(.F(F)) u_product (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(sc_vld),
		.sin_a(sa), .cos_a(ca), .sin_b(sb), .cos_b(cb), .cos_d(cd),
		.out_vld(prod_vld), .c(c_val)
	);

	// acos(c) = 2 atan2(sqrt(1 - c), sqrt(1 + c)), roots with 31 fraction bits
	assign one_m_c = unsigned'(ONE_C - (F+3)'(c_val));
	assign one_p_c = unsigned'(ONE_C + (F+3)'(c_val));
	assign op_y = gcd_pkg::RAD_W'(one_m_c) << (62 - F);
	assign op_x = gcd_pkg::RAD_W'(one_p_c) << (62 - F);

	gcd_sqrt u_sqrt_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(prod_vld), .op(op_y),
		.out_vld(rt_vld), .root(root_y)
	);

	gcd_sqrt u_sqrt_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(prod_vld), .op(op_x),
		.out_vld(), .root(root_x)
	);

	gcd_arc #(.F(F)) u_arc (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(rt_vld),
		.root_x(root_x), .root_y(root_y), .out_vld(m_tvalid),
		.dist_centikm(dist_centikm)
	);

	assign m_tdata = gcd_pkg::OUT_W'(dist_centikm);

	`GCD_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "word taken while output stalled")
	`GCD_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_s1, "accepted word missing from first stage")
	`GCD_ASSERT_NOW(a_cos_arg_range, prod_vld, (c_val <= ONE_C) && (c_val >= -ONE_C), "cosine argument outside clamp")
endmodule

// ----- sim/tb_great_circle_distance.sv -----
// self-checking stream testbench for the great circle distance pipeline
`timescale 1ns / 1ps
module tb_great_circle_distance;
	localparam int FRAC = 24;
	localparam int N_RANDOM = 1200;
	localparam int DRAIN_CYCLES = 150;
	localparam longint unsigned PI_Q61 = 64'h6487ED5110B4611A;
	localparam longint unsigned SEC_TO_RAD_Q61 = (PI_Q61 + 64'd324000) / 64'd648000;
	localparam longint unsigned CORDIC_GAIN_Q62 = 64'd2800459870029452954;
	localparam longint unsigned RADIUS_CKM_Q20 = 64'd668822457549;
	localparam longint TURN_SEC = 1296000;
	localparam longint HALF_SEC = 648000;
	localparam longint QUARTER_SEC = 324000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [gcd_pkg::IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [gcd_pkg::OUT_W-1:0] m_tdata;

	logic [gcd_pkg::IN_W-1:0] pair_queue[$];
	logic [gcd_pkg::DIST_W-1:0] dist_queue[$];
	longint atan_q[FRAC];
	int pairs_sent;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_cycles;
	bit hold_done;
	int errors;

	great_circle_distance uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// atan(2^-i) from the series, rounded to FRAC fraction bits
	function automatic void build_atan_table();
		longint unsigned acc;
		longint unsigned term;
		int e;
		for (int i = 0; i < FRAC; i++) begin
			acc = 0;
			if (i == 0) begin
				acc = (PI_Q61 + 64'd1) >> 1;
			end else begin
				for (int k = 0; k < 64; k++) begin
					e = i * (2 * k + 1);
					if (e <= 62) begin
						term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
						if (k % 2 == 1) acc = acc - term;
						else acc = acc + term;
					end
				end
			end
			atan_q[i] = longint'((acc + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
		end
	endfunction

	function automatic longint unsigned scaled_product(longint unsigned a,
			longint unsigned b, int s);
		logic [127:0] p;
		p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
		return 64'(p >> s);
	endfunction

	function automatic longint frac_mul(longint a, longint b);
		longint unsigned ua;
		longint unsigned ub;
		longint r;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		r = longint'(scaled_product(ua, ub, FRAC));
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// rotation cordic on an angle given in arc seconds
	function automatic void arcsec_sincos(longint s, output longint cs, output longint sn);
		longint r;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint unsigned mag;
		longint unsigned a;
		bit flip;
		flip = 0;
		r = s % TURN_SEC;
		if (r > HALF_SEC) r -= TURN_SEC;
		if (r <= -HALF_SEC) r += TURN_SEC;
		if (r > QUARTER_SEC) begin
			r -= HALF_SEC;
			flip = 1;
		end else if (r < -QUARTER_SEC) begin
			r += HALF_SEC;
			flip = 1;
		end
		mag = r < 0 ? -r : r;
		a = (mag * SEC_TO_RAD_Q61 + (64'd1 << (60 - FRAC))) >> (61 - FRAC);
		z = r < 0 ? -longint'(a) : longint'(a);
		x = longint'((CORDIC_GAIN_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
		y = 0;
		for (int i = 0; i < FRAC; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_q[i];
			end else begin
				x += dx; y -= dy; z += atan_q[i];
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic longint to_arcsec(longint deg, logic [5:0] mn, logic [5:0] sc);
		return deg * 3600 + longint'(mn) * 60 + longint'(sc);
	endfunction

	function automatic logic [gcd_pkg::DIST_W-1:0] predict_distance(
			logic [gcd_pkg::IN_W-1:0] w);
		longint lat_a;
		longint lon_a;
		longint lat_b;
		longint lon_b;
		longint ca, sa, cb, sb, cd, sd, c, x, y, z, dx, dy, theta;
		longint one;
		one = longint'(1) << FRAC;
		lat_a = to_arcsec(longint'($signed(w[7:0])), w[13:8], w[19:14]);
		lon_a = to_arcsec(longint'($signed(w[28:20])), w[34:29], w[40:35]);
		lat_b = to_arcsec(longint'($signed(w[48:41])), w[54:49], w[60:55]);
		lon_b = to_arcsec(longint'($signed(w[69:61])), w[75:70], w[81:76]);
		arcsec_sincos(lat_a, ca, sa);
		arcsec_sincos(lat_b, cb, sb);
		arcsec_sincos(lon_b - lon_a, cd, sd);
		c = frac_mul(sa, sb) + frac_mul(frac_mul(ca, cb), cd);
		if (c > one) c = one;
		if (c < -one) c = -one;
		y = longint'(floor_sqrt(longint'(one - c) << (62 - FRAC)));
		x = longint'(floor_sqrt(longint'(one + c) << (62 - FRAC)));
		z = 0;
		// vectoring cordic gives atan2(y, x)
		for (int i = 0; i < FRAC; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_q[i];
			end else begin
				x -= dx; y += dy; z -= atan_q[i];
			end
		end
		theta = 2 * z;
		if (theta < 0) theta = 0;
		return gcd_pkg::DIST_W'(scaled_product(theta, RADIUS_CKM_Q20, FRAC + 20));
	endfunction

	function automatic logic [gcd_pkg::IN_W-1:0] pack_pair(int la_d, int la_m, int la_s,
			int lo_d, int lo_m, int lo_s, int lb_d, int lb_m, int lb_s,
			int ob_d, int ob_m, int ob_s);
		logic [gcd_pkg::IN_W-1:0] w;
		w = '0;
		w[81:0] = {6'(ob_s), 6'(ob_m), 9'(ob_d), 6'(lb_s), 6'(lb_m), 8'(lb_d),
			6'(lo_s), 6'(lo_m), 9'(lo_d), 6'(la_s), 6'(la_m), 8'(la_d)};
		return w;
	endfunction

	function automatic logic [gcd_pkg::IN_W-1:0] random_pair();
		int kind;
		int la, lo;
		logic [gcd_pkg::IN_W-1:0] w;
		kind = $urandom_range(0, 99);
		la = $urandom_range(0, 180) - 90;
		lo = $urandom_range(0, 360) - 180;
		if (kind < 10) begin
			// raw bit patterns, out of range fields included
			w = '0;
			w[81:0] = 82'({$urandom, $urandom, $urandom});
		end else if (kind < 18) begin
			w = pack_pair(la, 0, 0, lo, 0, 0, -la, 0, 0, lo + 180, 0, 0);
		end else if (kind < 26) begin
			w = pack_pair(la, $urandom_range(0, 59), $urandom_range(0, 59), lo,
				$urandom_range(0, 59), $urandom_range(0, 59), 0, 0, 0, 0, 0, 0);
			w[81:41] = w[40:0];
		end else begin
			w = pack_pair(la, $urandom_range(0, 59), $urandom_range(0, 59),
				lo, $urandom_range(0, 59), $urandom_range(0, 59),
				$urandom_range(0, 180) - 90, $urandom_range(0, 59),
				$urandom_range(0, 59), $urandom_range(0, 360) - 180,
				$urandom_range(0, 59), $urandom_range(0, 59));
		end
		return w;
	endfunction

	initial begin
		build_atan_table();
		// zero, coincident, antipodal, poles, date line
		pair_queue.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pair_queue.push_back(pack_pair(48, 47, 0, 9, 11, 0, 48, 47, 0, 9, 11, 0));
		pair_queue.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 180, 0, 0));
		pair_queue.push_back(pack_pair(90, 0, 0, 0, 0, 0, -90, 0, 0, 0, 0, 0));
		pair_queue.push_back(pack_pair(-90, 0, 0, 17, 0, 0, -90, 0, 0, -163, 0, 0));
		pair_queue.push_back(pack_pair(30, 0, 0, -180, 0, 0, -30, 0, 0, 0, 0, 0));
		pair_queue.push_back(pack_pair(0, 0, 0, 180, 0, 0, 0, 0, 0, -180, 0, 0));
		pair_queue.push_back(pack_pair(89, 59, 59, 179, 59, 59, -89, 59, 59, -179, 59, 59));
		// negative degrees with minutes that add
		pair_queue.push_back(pack_pair(-10, 30, 0, -1, 0, 30, -9, 30, 0, 0, 59, 30));
		pair_queue.push_back(pack_pair(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		// fields beyond range carry or wrap
		pair_queue.push_back(pack_pair(127, 63, 63, 255, 63, 63, -128, 63, 63, -256, 63, 63));
		pair_queue.push_back(pack_pair(-128, 0, 0, -256, 0, 0, 127, 0, 0, 255, 0, 0));
		pair_queue.push_back(pack_pair(100, 60, 60, 200, 60, 60, -100, 0, 0, -200, 0, 0));
		pair_queue.push_back(pack_pair(45, 0, 0, 90, 0, 0, -45, 0, 0, -90, 0, 0));
		pair_queue.push_back(pack_pair(-1, 59, 59, -1, 59, 59, 0, 0, 1, 0, 0, 1));
		for (int i = 0; i < N_RANDOM; i++) pair_queue.push_back(random_pair());
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// idle rates follow how far the stimulus has got
	always_comb begin
		if (pairs_sent < 420) begin
			tx_idle_pct = 14;
			rx_idle_pct = 46;
		end else if (pairs_sent < 820) begin
			tx_idle_pct = 46;
			rx_idle_pct = 14;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			pairs_sent <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (pair_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_tdata <= pair_queue[0];
				dist_queue.push_back(predict_distance(pair_queue.pop_front()));
				s_tvalid <= 1'b1;
				pairs_sent <= pairs_sent + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off during the idle-free phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (!hold_done && pairs_sent >= 850) begin
			m_tready <= 1'b0;
			hold_cycles <= 400;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_queue.size() == 0) begin
				$error("distance_centikm: unexpected word %0d",
					m_tdata[gcd_pkg::DIST_W-1:0]);
				errors++;
			end else begin
				if (m_tdata[gcd_pkg::DIST_W-1:0] !== dist_queue[0]) begin
					$error("distance_centikm: expected %0d, got %0d",
						dist_queue[0], m_tdata[gcd_pkg::DIST_W-1:0]);
					errors++;
				end
				void'(dist_queue.pop_front());
			end
		end
	end

	initial begin
		errors = 0;
		@(posedge arst_n);
		wait (pair_queue.size() == 0 && !s_tvalid && dist_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && dist_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/gcd_pkg.sv
hdl/gcd_sincos.sv
hdl/gcd_product.sv
hdl/gcd_sqrt.sv
hdl/gcd_arc.sv
hdl/great_circle_distance.sv
sim/tb_great_circle_distance.sv
